>>> design/mowm_pkg.sv
// ----------------------------------------------------------------------------
// mowm_pkg
// Shared types, defaults and sequencer codes for the max-of-window-minimums
// block.
// ----------------------------------------------------------------------------
package mowm_pkg;

    localparam int MAX_LEN_DEF    = 64;
    localparam int VALUE_BITS_DEF = 31;

    typedef struct packed {
        logic [30:0] sample_value;
        logic        end_of_set;
    } in_word_t;

    typedef struct packed {
        logic [6:0]  window_size;
        logic [30:0] best_minimum;
        logic        final_result;
        logic        truncated;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_L_RD,
        ST_L_CMP,
        ST_L_TOP,
        ST_R_RD,
        ST_R_CMP,
        ST_R_TOP,
        ST_R_UPD,
        ST_S_RD,
        ST_S_WR,
        ST_E_RD,
        ST_E_LD
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_L_READ,
        OP_POP,
        OP_TOP,
        OP_L_PUSH,
        OP_R_READ,
        OP_R_PUSH,
        OP_R_UPD,
        OP_S_READ,
        OP_S_WRITE,
        OP_E_READ,
        OP_E_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic eos_fire;
        logic i_eq_n;
        logic i_last;
        logic i_zero;
        logic i_one;
        logic pop_left;
        logic pop_right;
        logic out_free;
    } status_t;

endpackage

>>> design/max_of_window_minimums_top.sv
// ----------------------------------------------------------------------------
// max_of_window_minimums_top
// Maximum of window minimums for every window size of a loaded sequence.
// ----------------------------------------------------------------------------
// Words are loaded at one per cycle until the word that carries end_of_set;
// words beyond MAX_LEN are dropped and flagged as truncated. The block then
// stops taking input and works through the n stored values: a clear of the
// per-length table, a left stack pass, a right stack pass with the span
// update, a suffix maximum and the emission of n results, which waits while
// the output is stalled. Each pass pops at most n - 1 times. Loading of the
// next set starts as soon as the last result sits in the output register.
module max_of_window_minimums_top #(
    parameter int MAX_LEN    = mowm_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = mowm_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mowm_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mowm_pkg::out_word_t out_data
);

    mowm_pkg::cmd_t    cmd;
    mowm_pkg::status_t status;

    mowm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mowm_dp #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> design/mowm_ctrl.sv
// ----------------------------------------------------------------------------
// mowm_ctrl
// Sequencer: load, table clear, left and right stack passes, suffix maximum
// and result emission.
// ----------------------------------------------------------------------------
module mowm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  mowm_pkg::status_t status,
    output mowm_pkg::cmd_t    cmd
);

    mowm_pkg::state_t state_reg;
    mowm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mowm_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mowm_pkg::ST_LOAD:
            begin
                if (status.eos_fire)
                    state_next = mowm_pkg::ST_CLEAR;
            end
            mowm_pkg::ST_CLEAR:
            begin
                if (status.i_eq_n)
                    state_next = mowm_pkg::ST_L_RD;
            end
            mowm_pkg::ST_L_RD:  state_next = mowm_pkg::ST_L_CMP;
            mowm_pkg::ST_L_CMP:
            begin
                if (status.pop_left)
                    state_next = mowm_pkg::ST_L_TOP;
                else if (status.i_last)
                    state_next = mowm_pkg::ST_R_RD;
                else
                    state_next = mowm_pkg::ST_L_RD;
            end
            mowm_pkg::ST_L_TOP: state_next = mowm_pkg::ST_L_CMP;
            mowm_pkg::ST_R_RD:  state_next = mowm_pkg::ST_R_CMP;
            mowm_pkg::ST_R_CMP:
            begin
                if (status.pop_right)
                    state_next = mowm_pkg::ST_R_TOP;
                else
                    state_next = mowm_pkg::ST_R_UPD;
            end
            mowm_pkg::ST_R_TOP: state_next = mowm_pkg::ST_R_CMP;
            mowm_pkg::ST_R_UPD:
            begin
                if (status.i_zero)
                    state_next = mowm_pkg::ST_S_RD;
                else
                    state_next = mowm_pkg::ST_R_RD;
            end
            mowm_pkg::ST_S_RD:  state_next = mowm_pkg::ST_S_WR;
            mowm_pkg::ST_S_WR:
            begin
                if (status.i_one)
                    state_next = mowm_pkg::ST_E_RD;
                else
                    state_next = mowm_pkg::ST_S_RD;
            end
            mowm_pkg::ST_E_RD:  state_next = mowm_pkg::ST_E_LD;
            mowm_pkg::ST_E_LD:
            begin
                if (status.out_free)
                    state_next = status.i_eq_n ? mowm_pkg::ST_LOAD : mowm_pkg::ST_E_RD;
            end
            default:            state_next = mowm_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd.op = mowm_pkg::OP_NONE;
        case (state_reg)
            mowm_pkg::ST_LOAD:  cmd.op = mowm_pkg::OP_LOAD;
            mowm_pkg::ST_CLEAR: cmd.op = mowm_pkg::OP_CLEAR;
            mowm_pkg::ST_L_RD:  cmd.op = mowm_pkg::OP_L_READ;
            mowm_pkg::ST_L_CMP:
                cmd.op = status.pop_left ? mowm_pkg::OP_POP : mowm_pkg::OP_L_PUSH;
            mowm_pkg::ST_L_TOP: cmd.op = mowm_pkg::OP_TOP;
            mowm_pkg::ST_R_RD:  cmd.op = mowm_pkg::OP_R_READ;
            mowm_pkg::ST_R_CMP:
                cmd.op = status.pop_right ? mowm_pkg::OP_POP : mowm_pkg::OP_R_PUSH;
            mowm_pkg::ST_R_TOP: cmd.op = mowm_pkg::OP_TOP;
            mowm_pkg::ST_R_UPD: cmd.op = mowm_pkg::OP_R_UPD;
            mowm_pkg::ST_S_RD:  cmd.op = mowm_pkg::OP_S_READ;
            mowm_pkg::ST_S_WR:  cmd.op = mowm_pkg::OP_S_WRITE;
            mowm_pkg::ST_E_RD:  cmd.op = mowm_pkg::OP_E_READ;
            mowm_pkg::ST_E_LD:  cmd.op = mowm_pkg::OP_E_LOAD;
            default:            cmd.op = mowm_pkg::OP_NONE;
        endcase
    end

endmodule

>>> design/mowm_dp.sv
// ----------------------------------------------------------------------------
// mowm_dp
// Datapath: sample, bound, stack and per-length memories, counters, the
// stack top and the output register.
// ----------------------------------------------------------------------------
module mowm_dp #(
    parameter int MAX_LEN    = mowm_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = mowm_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mowm_pkg::cmd_t      cmd,
    output mowm_pkg::status_t   status,
    input  logic                in_valid,
    output logic                in_ready,
    input  mowm_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mowm_pkg::out_word_t out_data
);

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [VALUE_BITS-1:0] smem [MAX_LEN];
    logic [CW-1:0]         lmem [MAX_LEN];
    logic [IW-1:0]         stk_idx_mem [MAX_LEN];
    logic [VALUE_BITS-1:0] stk_val_mem [MAX_LEN];
    logic [VALUE_BITS-1:0] bmem [MAX_LEN + 1];

    logic [VALUE_BITS-1:0] smem_q;
    logic [CW-1:0]         lmem_q;
    logic [IW-1:0]         stk_idx_q;
    logic [VALUE_BITS-1:0] stk_val_q;
    logic [VALUE_BITS-1:0] bmem_q;

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         sp_reg, sp_next;
    logic [IW-1:0]         top_idx_reg, top_idx_next;
    logic [VALUE_BITS-1:0] top_val_reg, top_val_next;
    logic [CW-1:0]         span_reg, span_next;
    logic [VALUE_BITS-1:0] run_reg, run_next;
    logic                  out_valid_reg, out_valid_next;
    mowm_pkg::out_word_t   out_reg, out_next;

    logic                  in_fire;
    logic                  out_free;
    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] run_max;
    logic [CW-1:0]         right_bound;

    logic                  smem_we, smem_re;
    logic [IW-1:0]         smem_waddr, smem_raddr;
    logic                  lmem_we, lmem_re;
    logic [CW-1:0]         lmem_wdata;
    logic                  stk_we, stk_re;
    logic [IW-1:0]         stk_waddr, stk_raddr;
    logic                  bmem_we, bmem_re;
    logic [CW-1:0]         bmem_waddr, bmem_raddr;
    logic [VALUE_BITS-1:0] bmem_wdata;

    assign in_ready    = (cmd.op == mowm_pkg::OP_LOAD);
    assign in_fire     = in_ready && in_valid;
    assign out_free    = !out_valid_reg || out_ready;
    assign in_val      = VALUE_BITS'(in_data.sample_value);
    assign run_max     = (bmem_q > run_reg) ? bmem_q : run_reg;
    assign right_bound = (sp_reg != '0) ? CW'(top_idx_reg) : cnt_reg;

    assign status.eos_fire  = in_fire && in_data.end_of_set;
    assign status.i_eq_n    = (i_reg == cnt_reg);
    assign status.i_last    = (i_reg + CW'(1) == cnt_reg);
    assign status.i_zero    = (i_reg == '0);
    assign status.i_one     = (i_reg == CW'(1));
    assign status.pop_left  = (sp_reg != '0) && (top_val_reg >= smem_q);
    assign status.pop_right = (sp_reg != '0) && (top_val_reg > smem_q);
    assign status.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        top_idx_next   = top_idx_reg;
        top_val_next   = top_val_reg;
        span_next      = span_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        smem_we    = 1'b0;
        smem_re    = 1'b0;
        smem_waddr = cnt_reg[IW-1:0];
        smem_raddr = i_reg[IW-1:0];
        lmem_we    = 1'b0;
        lmem_re    = 1'b0;
        lmem_wdata = (sp_reg != '0) ? CW'(top_idx_reg) + CW'(1) : '0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_waddr  = sp_reg[IW-1:0];
        stk_raddr  = IW'(sp_reg - CW'(2));
        bmem_we    = 1'b0;
        bmem_re    = 1'b0;
        bmem_waddr = i_reg;
        bmem_raddr = i_reg;
        bmem_wdata = '0;

        case (cmd.op)
            mowm_pkg::OP_LOAD:
            begin
                if (in_fire)
                begin
                    if (cnt_reg < CW'(MAX_LEN))
                    begin
                        smem_we  = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_data.end_of_set)
                        i_next = CW'(1);
                end
            end
            mowm_pkg::OP_CLEAR:
            begin
                bmem_we = 1'b1;
                if (i_reg == cnt_reg)
                begin
                    i_next  = '0;
                    sp_next = '0;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            mowm_pkg::OP_L_READ:
            begin
                smem_re = 1'b1;
            end
            mowm_pkg::OP_POP:
            begin
                // The entry below the popped one becomes the new top.
                sp_next = sp_reg - CW'(1);
                stk_re  = 1'b1;
            end
            mowm_pkg::OP_TOP:
            begin
                top_idx_next = stk_idx_q;
                top_val_next = stk_val_q;
            end
            mowm_pkg::OP_L_PUSH:
            begin
                lmem_we      = 1'b1;
                stk_we       = 1'b1;
                sp_next      = sp_reg + CW'(1);
                top_idx_next = i_reg[IW-1:0];
                top_val_next = smem_q;
                if (i_reg + CW'(1) == cnt_reg)
                begin
                    sp_next = '0;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            mowm_pkg::OP_R_READ:
            begin
                smem_re = 1'b1;
                lmem_re = 1'b1;
            end
            mowm_pkg::OP_R_PUSH:
            begin
                span_next    = right_bound - lmem_q;
                bmem_re      = 1'b1;
                bmem_raddr   = right_bound - lmem_q;
                stk_we       = 1'b1;
                sp_next      = sp_reg + CW'(1);
                top_idx_next = i_reg[IW-1:0];
                top_val_next = smem_q;
            end
            mowm_pkg::OP_R_UPD:
            begin
                bmem_waddr = span_reg;
                bmem_wdata = smem_q;
                bmem_we    = (smem_q > bmem_q);
                if (i_reg == '0)
                begin
                    i_next   = cnt_reg;
                    run_next = '0;
                end
                else
                begin
                    i_next = i_reg - CW'(1);
                end
            end
            mowm_pkg::OP_S_READ:
            begin
                bmem_re = 1'b1;
            end
            mowm_pkg::OP_S_WRITE:
            begin
                run_next   = run_max;
                bmem_we    = 1'b1;
                bmem_wdata = run_max;
                if (i_reg != CW'(1))
                    i_next = i_reg - CW'(1);
            end
            mowm_pkg::OP_E_READ:
            begin
                bmem_re = 1'b1;
            end
            mowm_pkg::OP_E_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.window_size  = 7'(i_reg);
                    out_next.best_minimum = 31'(bmem_q);
                    out_next.final_result = (i_reg == cnt_reg);
                    out_next.truncated    = ovf_reg;
                    if (i_reg == cnt_reg)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                        sp_next  = '0;
                    end
                    else
                    begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_idx_reg <= top_idx_next;
        top_val_reg <= top_val_next;
        span_reg    <= span_next;
        run_reg     <= run_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
            smem[smem_waddr] <= in_val;
        if (smem_re)
            smem_q <= smem[smem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lmem_we)
            lmem[i_reg[IW-1:0]] <= lmem_wdata;
        if (lmem_re)
            lmem_q <= lmem[i_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_idx_mem[stk_waddr] <= i_reg[IW-1:0];
            stk_val_mem[stk_waddr] <= smem_q;
        end
        if (stk_re)
        begin
            stk_idx_q <= stk_idx_mem[stk_raddr];
            stk_val_q <= stk_val_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bmem_we)
            bmem[bmem_waddr] <= bmem_wdata;
        if (bmem_re)
            bmem_q <= bmem[bmem_raddr];
    end

endmodule

>>> design/mowm_checker.sv
// ----------------------------------------------------------------------------
// mowm_checker
// Port-level checks for the max-of-window-minimums block.
// ----------------------------------------------------------------------------
module mowm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input mowm_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input mowm_pkg::out_word_t out_data
);

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // After the closing word the block computes and takes no input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.end_of_set |=> !in_ready)
        else $error("input taken right after closing word");

    // Results never carry a zero window size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.window_size != 7'd0)
        else $error("zero window size");

    // While a non-final result is on offer the block takes no input.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.final_result |-> !in_ready)
        else $error("input taken while results remain");

endmodule

bind max_of_window_minimums_top mowm_checker u_mowm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives sequences of samples into the max-of-window-minimums block and checks
// every result word against a local predictor of the best window minimum.
// ----------------------------------------------------------------------------

class window_min_board;
    mowm_pkg::out_word_t pending_results[$];
    bit [30:0] set_samples[$];
    bit        set_overflow;
    int        error_count;

    function void note_sample(mowm_pkg::in_word_t w);
        bit [30:0] v[$];
        int        n;
        int        lft[64];
        int        rgt[64];
        int        stk[$];
        bit [30:0] best[0:64];
        int        span;
        mowm_pkg::out_word_t r;
        if (set_samples.size() < 64)
            set_samples.insert(set_samples.size(), w.sample_value);
        else
            set_overflow = 1'b1;
        if (!w.end_of_set)
            return;
        v = set_samples;
        n = v.size();
        for (int i = 0; i <= 64; i++)
            best[i] = '0;
        stk.delete();
        for (int i = 0; i < n; i++)
        begin
            while (stk.size() > 0 && v[stk[$]] >= v[i])
                void'(stk.pop_back());
            lft[i] = (stk.size() > 0) ? stk[$] + 1 : 0;
            stk.insert(stk.size(), i);
        end
        stk.delete();
        for (int i = n - 1; i >= 0; i--)
        begin
            while (stk.size() > 0 && v[stk[$]] > v[i])
                void'(stk.pop_back());
            rgt[i] = (stk.size() > 0) ? stk[$] : n;
            stk.insert(stk.size(), i);
        end
        for (int i = 0; i < n; i++)
        begin
            span = rgt[i] - lft[i];
            if (v[i] > best[span])
                best[span] = v[i];
        end
        for (int i = n; i > 1; i--)
            if (best[i] > best[i - 1])
                best[i - 1] = best[i];
        for (int k = 1; k <= n; k++)
        begin
            r.window_size  = k[6:0];
            r.best_minimum = best[k];
            r.final_result = (k == n);
            r.truncated    = set_overflow;
            pending_results.insert(pending_results.size(), r);
        end
        set_samples.delete();
        set_overflow = 1'b0;
    endfunction

    function void report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endfunction

    function void check_result(mowm_pkg::out_word_t r);
        mowm_pkg::out_word_t e;
        if (pending_results.size() == 0)
        begin
            report("unexpected word, size", int'(r.window_size), 0);
            return;
        end
        e = pending_results.pop_front();
        if (r.window_size != e.window_size)
            report("window_size", int'(r.window_size), int'(e.window_size));
        if (r.best_minimum != e.best_minimum)
            report("best_minimum", int'(r.best_minimum), int'(e.best_minimum));
        if (r.final_result != e.final_result)
            report("final_result", int'(r.final_result), int'(e.final_result));
        if (r.truncated != e.truncated)
            report("truncated", int'(r.truncated), int'(e.truncated));
    endfunction
endclass

module tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mowm_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    mowm_pkg::out_word_t out_data;

    window_min_board board;
    int  cycle_count = 0;
    bit  calm_phase;
    bit  hold_off;

    max_of_window_minimums_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Accepted words are scored at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_sample(in_data);
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else if (calm_phase)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 17);
    end

    function automatic bit [30:0] pick_value(int mode);
        case (mode)
            0: return 31'($urandom_range(7));
            1: return 31'(32'h7fffffff - $urandom_range(3));
            default: return 31'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next word can follow with no gap.
    task automatic send_word(bit [30:0] value, bit last);
        if (!calm_phase)
            while ($urandom_range(99) < 17)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        in_data.sample_value <= value;
        in_data.end_of_set   <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_set(int len, int mode);
        for (int i = 0; i < len; i++)
            send_word(pick_value(mode), i == len - 1);
    endtask

    initial
    begin
        int len;
        board      = new();
        in_valid   = 1'b0;
        in_data    = '0;
        rst_n      = 1'b0;
        calm_phase = 1'b0;
        hold_off   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Directed: single element, extremes, equal runs, monotone runs.
        send_word(31'h0, 1'b1);
        send_word(31'h7fffffff, 1'b1);
        send_word(31'h5, 1'b0);
        send_word(31'h5, 1'b0);
        send_word(31'h5, 1'b1);
        for (int i = 0; i < 5; i++)
            send_word(31'(i), i == 4);
        for (int i = 0; i < 5; i++)
            send_word(31'(32'h7fffffff - i), i == 4);
        send_word(31'h2aaaaaaa, 1'b0);
        send_word(31'h55555555, 1'b1);
        // Overflow with the closing word dropped.
        send_set(66, 2);
        calm_phase = 1'b1;
        send_set(40, 0);
        calm_phase = 1'b0;
        // Long output stall while input keeps coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_set(20, 2);
                send_set(10, 0);
            end
        join
        for (int s = 0; s < 34; s++)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            send_set(len, $urandom_range(2));
        end
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> max_of_window_minimums_top.f
design/mowm_pkg.sv
design/mowm_ctrl.sv
design/mowm_dp.sv
design/max_of_window_minimums_top.sv
design/mowm_checker.sv
test/tb.sv
